// ===== rtl/core/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Holds request action codes, error codes and the cell control bundle.
// No dependencies.
`default_nettype none

package deq_pkg;

    // Request action codes; unused codes behave as peek
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK       = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } error_t;

    // What every cell of the chain does on an update
    typedef enum logic [2:0] {
        CELL_HOLD,        // keep contents
        CELL_SHIFT_UP,    // take the neighbour nearer the front (push front)
        CELL_SHIFT_DOWN,  // take the neighbour nearer the back (pop front)
        CELL_APPEND,      // first free cell loads the pushed word (push back)
        CELL_DROP         // last occupied cell empties (pop back)
    } cell_op_t;

    typedef struct packed {
        logic     update;
        cell_op_t op;
    } cell_ctrl_t;

    localparam int ACTION_W = 3;
    localparam int ERROR_W  = 2;

endpackage

`default_nettype wire

// ===== rtl/core/deq_cell.sv =====
// One storage cell of the deque chain: a word and its occupied flag.
// Exchanges contents with both neighbours; depends on deq_pkg.
`default_nettype none

module deq_cell #(
    parameter int WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  logic [WIDTH-1:0]  push_value,
    input  logic              prev_valid,
    input  logic [WIDTH-1:0]  prev_value,
    input  logic              next_valid,
    input  logic [WIDTH-1:0]  next_value,
    output logic              valid,
    output logic [WIDTH-1:0]  value,
    output logic              is_last
);
    import deq_pkg::*;

    logic             valid_reg, valid_next;
    logic [WIDTH-1:0] value_reg, value_next;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.update) begin
            case (ctrl.op)
                CELL_SHIFT_UP: begin
                    valid_next = prev_valid;
                    value_next = prev_value;
                end
                CELL_APPEND: begin
                    valid_next = prev_valid;
                    if (prev_valid && !valid_reg) begin
                        value_next = push_value;
                    end
                end
                CELL_SHIFT_DOWN: begin
                    valid_next = next_valid;
                    value_next = next_value;
                end
                CELL_DROP: begin
                    valid_next = next_valid;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset: an empty cell is never shown
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid   = valid_reg;
    assign value   = value_reg;
    assign is_last = valid_reg && !next_valid;

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: a chain of deq_cell stages.
// Depends on deq_pkg and deq_cell.
//
// Usage:
//   Input channel s_*: s_tuser carries the action (push front, push back,
//   pop front, pop back, peek; other codes act as peek), s_tdata the word to
//   push. Each accepted request yields exactly one result on m_*: front and
//   back words (zero when empty), empty and full flags, count and error code.
//   Storage: DEPTH cells in a row, front always in cell 0, each cell taking
//   its word from a neighbour when the queue shifts. Occupancy is a
//   thermometer of cell flags, mirrored by a binary counter.
//   Timing: the cells update at the accepting edge; the result is then held
//   pending and is loaded into the output register once that is free, which
//   raises m_tvalid.
//   Throughput: one request per cycle while m_tready is high; the back word
//   is picked by an AND-OR over all DEPTH cells in the output stage.
//   Stall: one request may wait behind a held result; s_tready then drops
//   until the output register is freed.
//   Reset (aresetn low, synchronous): queue empty, no result pending.
//   Pop on empty or push on full leaves the queue unchanged, flags error.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    // s_tdata: value [WIDTH-1:0], zero padding to whole bytes
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((WIDTH+7)/8)*8-1:0]         s_tdata,
    // s_tuser: action [2:0]
    input  logic [deq_pkg::ACTION_W-1:0]       s_tuser,
    // m_tdata, lowest bit up: first_value, last_value, is_empty, is_full,
    // count, error, zero padding to whole bytes
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((2*WIDTH+4+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);
    import deq_pkg::*;

    localparam int CW       = $clog2(DEPTH + 1);
    localparam int OUT_W    = ((2*WIDTH + 4 + CW + 7) / 8) * 8;
    localparam int OFS_LAST = WIDTH;
    localparam int OFS_EMP  = 2 * WIDTH;
    localparam int OFS_FULL = 2 * WIDTH + 1;
    localparam int OFS_CNT  = 2 * WIDTH + 2;
    localparam int OFS_ERR  = 2 * WIDTH + 2 + CW;
    localparam logic [CW-1:0] ONE = CW'(1);

    logic [WIDTH-1:0] push_value;
    logic             accept;
    logic             load;
    cell_ctrl_t       ctrl;
    error_t           err_next;

    logic             pend_reg, pend_next;
    error_t           err_reg;
    logic [CW-1:0]    count_reg, count_next;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_last;
    logic [WIDTH-1:0] cell_value [DEPTH];
    logic [WIDTH-1:0] back_word;

    assign push_value = s_tdata[WIDTH-1:0];

    // free the pending slot when the output register takes it
    assign load     = pend_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_reg || load;
    assign accept   = s_tvalid && s_tready;

    // decode the request into a chain operation, error and new count
    always_comb begin
        ctrl.update = accept;
        ctrl.op     = CELL_HOLD;
        err_next    = ERR_NONE;
        count_next  = count_reg;
        if (accept) begin
            unique case (action_t'(s_tuser))
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (cell_valid[DEPTH-1]) begin
                        err_next = ERR_FULL;
                    end else begin
                        ctrl.op    = (action_t'(s_tuser) == ACT_PUSH_FRONT) ?
                                     CELL_SHIFT_UP : CELL_APPEND;
                        count_next = count_reg + ONE;
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK: begin
                    if (!cell_valid[0]) begin
                        err_next = ERR_EMPTY;
                    end else begin
                        ctrl.op    = (action_t'(s_tuser) == ACT_POP_FRONT) ?
                                     CELL_SHIFT_DOWN : CELL_DROP;
                        count_next = count_reg - ONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // chain of cells, front word held in cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic             prev_valid, next_valid;
        logic [WIDTH-1:0] prev_value, next_value;

        if (i == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign prev_value = push_value;
        end else begin : g_body
            assign prev_valid = cell_valid[i-1];
            assign prev_value = cell_value[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_value = '0;
        end else begin : g_inner
            assign next_valid = cell_valid[i+1];
            assign next_value = cell_value[i+1];
        end

        deq_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .push_value (push_value),
            .prev_valid (prev_valid),
            .prev_value (prev_value),
            .next_valid (next_valid),
            .next_value (next_value),
            .valid      (cell_valid[i]),
            .value      (cell_value[i]),
            .is_last    (cell_last[i])
        );
    end

    // back word: exactly one cell marks itself last when not empty
    always_comb begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_word = back_word | (cell_value[i] & {WIDTH{cell_last[i]}});
        end
    end

    // result of the pending request, read from the cells as they now stand
    always_comb begin
        out_data_next                          = '0;
        out_data_next[WIDTH-1:0]               = cell_valid[0] ? cell_value[0] : '0;
        out_data_next[OFS_LAST +: WIDTH]       = back_word;
        out_data_next[OFS_EMP]                 = !cell_valid[0];
        out_data_next[OFS_FULL]                = cell_valid[DEPTH-1];
        out_data_next[OFS_CNT +: CW]           = count_reg;
        out_data_next[OFS_ERR +: ERROR_W]      = err_reg;
    end

    always_comb begin
        pend_next = pend_reg;
        if (accept) begin
            pend_next = 1'b1;
        end else if (load) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            count_reg <= count_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err_reg <= err_next;
        end
        if (load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // occupancy flags form a thermometer from the front cell
    a_thermometer: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid & ~((cell_valid << 1) | DEPTH'(1))) == '0)
        else $error("cell occupancy is not contiguous from the front");

    // binary count tracks the cell flags
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("count disagrees with occupied cells");

    // a non-empty queue has exactly one back cell
    a_back: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_last) && ((cell_last != '0) == cell_valid[0]))
        else $error("back cell marking broken");

    // a stalled input always has a request waiting behind a held result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (pend_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");

endmodule

`default_nettype wire

// ===== test/double_ended_queue_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for double_ended_queue: drives random push, pop and peek requests.
// Checks each result against a behavioural model of the queue. Depends on deq_pkg and the RTL.

module double_ended_queue_test;

    import deq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int WIDTH     = 32;
    localparam int S_W       = ((WIDTH + 7) / 8) * 8;
    localparam int LEVEL_W   = $clog2(DEPTH + 1);
    localparam int M_W       = ((2 * WIDTH + 4 + LEVEL_W + 7) / 8) * 8;
    // Result bus layout, lowest bit up
    localparam int EMPTY_BIT = 2 * WIDTH;
    localparam int FULL_BIT  = 2 * WIDTH + 1;
    localparam int LEVEL_LSB = 2 * WIDTH + 2;
    localparam int ERR_LSB   = LEVEL_LSB + LEVEL_W;
    localparam int CODE_MAX  = 2 ** ACTION_W - 1;
    localparam int PHASE_REQUESTS = 155;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PRINT_CAP      = 30;

    typedef struct packed {
        logic [WIDTH-1:0]   front_word;
        logic [WIDTH-1:0]   back_word;
        logic               empty_flag;
        logic               full_flag;
        logic [LEVEL_W-1:0] level;
        error_t             err;
    } deque_status_t;

    // Model of the queue: ring store, head pointer, level and the results still owed
    class deque_shadow;
        logic [WIDTH-1:0]       ring [DEPTH];
        logic [$clog2(DEPTH)-1:0] head;
        int                     level;
        deque_status_t          owed [$];
        int                     mismatches;

        function new();
            head       = '0;
            level      = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted request and queue the status it must produce
        function void note_request(logic [ACTION_W-1:0] code, logic [WIDTH-1:0] word);
            deque_status_t st;
            error_t        err;
            err = ERR_NONE;
            case (code)
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (level == DEPTH) begin
                        err = ERR_FULL;
                    end else if (code == ACT_PUSH_FRONT) begin
                        head = head - 1'b1;
                        ring[head] = word;
                        level++;
                    end else begin
                        ring[head + level[$clog2(DEPTH)-1:0]] = word;
                        level++;
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK: begin
                    if (level == 0) begin
                        err = ERR_EMPTY;
                    end else begin
                        if (code == ACT_POP_FRONT)
                            head = head + 1'b1;
                        level--;
                    end
                end
                default: ;  // peek and spare codes leave the queue alone
            endcase
            st.front_word = '0;
            st.back_word  = '0;
            if (level != 0) begin
                st.front_word = ring[head];
                st.back_word  = ring[head + 4'(level - 1)];
            end
            st.empty_flag = (level == 0);
            st.full_flag  = (level == DEPTH);
            st.level      = LEVEL_W'(level);
            st.err        = err;
            owed.push_back(st);
        endfunction

        task report_mismatch(string what, logic [WIDTH-1:0] got, logic [WIDTH-1:0] want);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        endtask

        // Compare one accepted result with the oldest status owed
        task check_result(logic [M_W-1:0] bus);
            deque_status_t want;
            if (owed.size() == 0) begin
                report_mismatch("result with no request outstanding", bus[WIDTH-1:0], '0);
                return;
            end
            want = owed.pop_front();
            if (bus[WIDTH-1:0] !== want.front_word)
                report_mismatch("front word", bus[WIDTH-1:0], want.front_word);
            if (bus[2*WIDTH-1:WIDTH] !== want.back_word)
                report_mismatch("back word", bus[2*WIDTH-1:WIDTH], want.back_word);
            if (bus[EMPTY_BIT] !== want.empty_flag)
                report_mismatch("empty flag", WIDTH'(bus[EMPTY_BIT]), WIDTH'(want.empty_flag));
            if (bus[FULL_BIT] !== want.full_flag)
                report_mismatch("full flag", WIDTH'(bus[FULL_BIT]), WIDTH'(want.full_flag));
            if (bus[LEVEL_LSB +: LEVEL_W] !== want.level)
                report_mismatch("count", WIDTH'(bus[LEVEL_LSB +: LEVEL_W]), WIDTH'(want.level));
            if (bus[ERR_LSB +: ERROR_W] !== want.err)
                report_mismatch("error code", WIDTH'(bus[ERR_LSB +: ERROR_W]), WIDTH'(want.err));
        endtask
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_W-1:0]      s_tdata  = '0;
    logic [ACTION_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_W-1:0]      m_tdata;

    int idle_pct  = 0;   // chance in a hundred that the sender holds off a cycle
    int stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int cycle_count = 0;
    deque_shadow shadow;

    double_ended_queue #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up on a hung run: well beyond the slowest correct one
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("double_ended_queue test failed");
        $finish;
    end

    // Result side: take results whenever ready, stall at the current rate
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                shadow.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Mostly random words, with the all-zero and all-one extremes often enough
    function automatic logic [WIDTH-1:0] pick_word();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return WIDTH'($urandom);
    endfunction

    // Offer one request, idling first at the current rate; hold it until taken
    task automatic send_request(input logic [ACTION_W-1:0] code, input logic [WIDTH-1:0] word);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= S_W'(word);
        do @(posedge aclk); while (!s_tready);
        shadow.note_request(code, word);
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (shadow.owed.size() != 0)
            @(posedge aclk);
    endtask

    // Random requests that steer the level towards a moving target, so the queue
    // keeps swinging between empty and full; at an extreme target, overrun it, else peek
    task automatic random_requests(input int n);
        int target;
        int r;
        target = DEPTH;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_request(ACTION_W'($urandom_range(int'(ACT_PEEK), CODE_MAX)), pick_word());
            end else if (r < 20) begin
                send_request(ACTION_W'($urandom_range(int'(ACT_POP_BACK))), pick_word());
            end else if (shadow.level < target) begin
                send_request($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_word());
            end else if (shadow.level > target) begin
                send_request($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_word());
            end else begin
                if (target == DEPTH)
                    send_request($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                                 pick_word());
                else if (target == 0)
                    send_request($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_word());
                else
                    send_request(ACT_PEEK, pick_word());
                case ($urandom_range(3))
                    0:       target = 0;
                    1:       target = DEPTH;
                    default: target = $urandom_range(DEPTH);
                endcase
            end
        end
    endtask

    initial begin
        shadow = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: errors on empty, both push ends with extreme words, both pops
        send_request(ACT_PEEK, '1);
        send_request(ACT_POP_FRONT, pick_word());
        send_request(ACT_POP_BACK, pick_word());
        send_request(ACT_PUSH_FRONT, '1);
        send_request(ACT_PUSH_BACK, '0);
        send_request(ACT_POP_BACK, pick_word());
        send_request(ACT_POP_FRONT, '1);
        // Fill from both ends, wrapping the head below zero, then overrun when full
        for (int i = 0; i < DEPTH; i++)
            send_request(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_word());
        send_request(ACT_PUSH_FRONT, '1);
        send_request(ACT_PUSH_BACK, '1);
        // Spare action codes act as peek
        for (int code = int'(ACT_PEEK) + 1; code <= CODE_MAX; code++)
            send_request(ACTION_W'(code), '1);

        // Phases: no idling, sender idle, receiver stalling, both sides idling
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 85; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            random_requests(PHASE_REQUESTS);
            wait_drained();
        end

        // Idle on for a while, catching any stray result
        repeat (10) @(posedge aclk);
        if (shadow.mismatches == 0)
            $display("double_ended_queue test passed");
        else
            $display("double_ended_queue test failed");
        $finish;
    end

endmodule
